>>> hdl/assert_macros.svh
// Assertion macros included by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> hdl/dbpp_pkg.sv
// Package for the dot-bracket pair parser: codes, widths and defaults.
package dbpp_pkg;

    // Defaults
    localparam int DBPP_MAX_LEN = 1024;
    localparam logic [3:0] MIN_DIST_RESET = 4'd4;

    // Field widths
    localparam int POS_W    = 10;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    // Symbol codes
    localparam logic [1:0] SYM_DOT   = 2'd0;
    localparam logic [1:0] SYM_OPEN  = 2'd1;
    localparam logic [1:0] SYM_CLOSE = 2'd2;
    localparam logic [1:0] SYM_OTHER = 2'd3;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_UNPAIRED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PAIRED   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK               = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED_CLOSE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HAIRPIN          = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SYMBOL       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PENDING          = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG         = 3'd5;

endpackage

>>> hdl/dot_bracket_pair_parser_unit.sv
// Dot-bracket structure parser: pairs open and close symbols through a stack memory.
//
// Usage:
//   Symbols enter on the s_ channel, one item per symbol; s_tlast marks the
//   final symbol of a structure string. Each symbol gives exactly one result
//   item on the m_ channel: its position, kind (m_tuser), partner position and
//   the sticky status code; m_tlast repeats the input's last mark.
//   Open positions live in a single-port-write, single-read stack memory of
//   MAX_LEN entries with a registered read. The entry that becomes the stack
//   top is read every cycle; a push in the same cycle is forwarded.
//   Latency: a result is valid the cycle after its symbol is accepted.
//   Throughput: one symbol per cycle while results are taken, bounded by the single memory read
//   that prefetches the stack top.
//   A stalled receiver holds the result register; s_tready stays low until
//   the held result is taken, then input resumes in the same cycle.
//   Reset (aresetn low, synchronous) empties the stack, clears the position
//   counter and status, and sets min_pair_distance to 4. The stack memory is
//   not cleared; entries are only used after being pushed. The last symbol of
//   each string returns the parser to that state (configuration is kept).
//   The user writes min_pair_distance via cfg_wr_en/cfg_wr_data only while idle (not enforced).
`include "assert_macros.svh"

module dot_bracket_pair_parser_unit
    import dbpp_pkg::*;
#(
    parameter int MAX_LEN = DBPP_MAX_LEN
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,   // min_pair_distance
    // symbol input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [1:0] symbol, [7:2] zero
    input  logic        s_tlast,       // last_symbol
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [9:0] position, [19:10] partner, [22:20] status, [23] zero
    output logic [1:0]  m_tuser,       // [1:0] kind
    output logic        m_tlast        // done_res
);

    localparam int PW   = $clog2(MAX_LEN);
    localparam int CNTW = $clog2(MAX_LEN + 1);
    localparam int CW   = (PW > 4) ? PW : 4;
    localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_LEN);

    // Control state
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [CNTW-1:0]     pos_reg, pos_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [3:0]          min_dist_reg;
    logic                fwd_reg;
    logic [PW-1:0]       fwd_pos_reg;

    // Stack memory
    logic [PW-1:0] stack_mem [MAX_LEN];
    logic [PW-1:0] stack_rd_reg;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] wr_addr;
    logic          push_we;

    // Output register
    logic                m_valid_reg;
    logic [POS_W-1:0]    out_pos_reg, out_partner_reg;
    logic [KIND_W-1:0]   out_kind_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_last_reg;

    // Per-item decode
    logic                in_acc;
    logic [1:0]          sym;
    logic [PW-1:0]       top;
    logic [PW-1:0]       pair_gap;
    logic                push, pop;
    logic [KIND_W-1:0]   kind;
    logic [PW-1:0]       partner;
    logic [CNTW-1:0]     cnt_after;
    logic [CNTW-1:0]     cnt_eff;

    // No item is taken while reset is held
    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign in_acc   = s_tvalid && s_tready;
    assign sym      = s_tdata[1:0];

    // Stack top: prefetched memory word, or the position pushed last cycle
    assign top      = fwd_reg ? fwd_pos_reg : stack_rd_reg;
    assign pair_gap = pos_reg[PW-1:0] - top;

    // Symbol evaluation
    always_comb begin
        push     = 1'b0;
        pop      = 1'b0;
        kind     = KIND_UNPAIRED;
        partner  = '0;
        err_next = err_reg;
        if (err_reg == ST_OK) begin
            if (pos_reg >= CNT_MAX) begin
                err_next = ST_TOO_LONG;
            end else begin
                unique case (sym)
                    SYM_DOT: begin
                        kind = KIND_UNPAIRED;
                    end
                    SYM_OPEN: begin
                        push = (cnt_reg < CNT_MAX);
                        kind = KIND_OPEN;
                    end
                    SYM_CLOSE: begin
                        if (cnt_reg == '0) begin
                            err_next = ST_UNEXPECTED_CLOSE;
                        end else if (CW'(pair_gap) < CW'(min_dist_reg)) begin
                            err_next = ST_HAIRPIN;
                        end else begin
                            pop     = 1'b1;
                            kind    = KIND_PAIRED;
                            partner = top;
                        end
                    end
                    default: begin
                        err_next = ST_BAD_SYMBOL;
                    end
                endcase
            end
        end

        cnt_after = cnt_reg;
        if (push) begin
            cnt_after = cnt_reg + 1'b1;
        end else if (pop) begin
            cnt_after = cnt_reg - 1'b1;
        end

        if (s_tlast && err_next == ST_OK && cnt_after != '0) begin
            err_next = ST_PENDING;
        end

        cnt_next = cnt_after;
        pos_next = (pos_reg < CNT_MAX) ? pos_reg + 1'b1 : pos_reg;
    end

    // Memory addressing: read the entry that becomes the top next cycle
    assign push_we = in_acc && push;
    assign wr_addr = cnt_reg[PW-1:0];
    assign cnt_eff = (in_acc && !s_tlast) ? cnt_next : ((in_acc) ? '0 : cnt_reg);
    assign rd_addr = PW'(cnt_eff - 1'b1);

    always_ff @(posedge aclk) begin
        if (push_we) begin
            stack_mem[wr_addr] <= pos_reg[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        stack_rd_reg <= stack_mem[rd_addr];
    end

    // Control state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            pos_reg      <= '0;
            err_reg      <= ST_OK;
            fwd_reg      <= 1'b0;
            min_dist_reg <= MIN_DIST_RESET;
        end else begin
            if (cfg_wr_en) begin
                min_dist_reg <= cfg_wr_data;
            end
            fwd_reg <= push_we;
            if (in_acc) begin
                if (s_tlast) begin
                    cnt_reg <= '0;
                    pos_reg <= '0;
                    err_reg <= ST_OK;
                end else begin
                    cnt_reg <= cnt_next;
                    pos_reg <= pos_next;
                    err_reg <= err_next;
                end
            end
        end
    end

    // Forwarded push data
    always_ff @(posedge aclk) begin
        if (push_we) begin
            fwd_pos_reg <= pos_reg[PW-1:0];
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            out_pos_reg     <= POS_W'(pos_reg);
            out_kind_reg    <= kind;
            out_partner_reg <= POS_W'(partner);
            out_status_reg  <= err_next;
            out_last_reg    <= s_tlast;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_status_reg, out_partner_reg, out_pos_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `ASSERT_IMPLIES(a_stack_le_pos, aclk, aresetn, 1'b1, cnt_reg <= pos_reg)
    `ASSERT_NEXT(a_last_clears, aclk, aresetn, in_acc && s_tlast,
        cnt_reg == '0 && pos_reg == '0 && err_reg == ST_OK)
    `ASSERT_NEXT(a_err_sticky, aclk, aresetn, err_reg != ST_OK && !in_acc,
        err_reg == $past(err_reg))

endmodule
